// File: sv/kl_pkg.sv
`timescale 1ns / 1ps

package kl_pkg;

    // Field widths of the token stream, keyword table sizes and queue depth.
    localparam int LINE_BITS       = 20;
    localparam int COLUMN_BITS     = 16;
    localparam int KEYWORD_MAX_LEN = 16;
    localparam int NUM_KEYWORDS    = 24;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = {COLUMN_BITS{1'b1}};

    // Token kinds.
    localparam logic [5:0] K_NEWLINE = 6'd0;
    localparam logic [5:0] K_STRING  = 6'd1;
    localparam logic [5:0] K_NUMBER  = 6'd2;
    localparam logic [5:0] K_LPAREN  = 6'd3;
    localparam logic [5:0] K_RPAREN  = 6'd4;
    localparam logic [5:0] K_COMMA   = 6'd5;
    localparam logic [5:0] K_COLON   = 6'd6;
    localparam logic [5:0] K_IDENT   = 6'd7;
    localparam logic [5:0] K_ERROR   = 6'd8;
    localparam logic [5:0] K_END     = 6'd9;
    localparam logic [5:0] K_KW0     = 6'd10;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;

    // Lexer modes, one-hot.
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_NUM     = 6'b000010,
        MODE_WORD    = 6'b000100,
        MODE_STR     = 6'b001000,
        MODE_ESC     = 6'b010000,
        MODE_COMMENT = 6'b100000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } lex_in_t;

    typedef struct packed {
        logic                   is_record;
        logic [5:0]             kind;
        logic [7:0]             text_byte;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic                   last_of_run;
    } lex_out_t;

    // All results caused by one source byte, oldest in slot 0.
    typedef struct packed {
        lex_out_t [3:0] res;
        logic [2:0]     count;
    } bundle_t;

    // Keyword spellings, right-justified.
    function automatic logic [8*KEYWORD_MAX_LEN-1:0] kw_word(input logic [4:0] k);
        logic [8*KEYWORD_MAX_LEN-1:0] w;
        w = '0;
        case (k)
            5'd0:  w = "let";
            5'd1:  w = "be";
            5'd2:  w = "add";
            5'd3:  w = "subtract";
            5'd4:  w = "multiply";
            5'd5:  w = "divide";
            5'd6:  w = "equals";
            5'd7:  w = {"not_", "equals"};
            5'd8:  w = {"less_", "than"};
            5'd9:  w = {"greater_", "than"};
            5'd10: w = {"less_or_", "equal"};
            5'd11: w = {"greater_or_", "equal"};
            5'd12: w = "and";
            5'd13: w = "or";
            5'd14: w = "not";
            5'd15: w = "if";
            5'd16: w = "then";
            5'd17: w = "else";
            5'd18: w = "end";
            5'd19: w = "while";
            5'd20: w = "begin";
            5'd21: w = "say";
            5'd22: w = "func";
            5'd23: w = "return";
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] kw_len(input logic [4:0] k);
        logic [4:0] n;
        n = 5'd0;
        case (k)
            5'd0, 5'd2, 5'd12, 5'd14, 5'd18, 5'd21: n = 5'd3;
            5'd1, 5'd13, 5'd15:                     n = 5'd2;
            5'd3, 5'd4:                             n = 5'd8;
            5'd5, 5'd6, 5'd23:                      n = 5'd6;
            5'd7:                                   n = 5'd10;
            5'd8:                                   n = 5'd9;
            5'd9:                                   n = 5'd12;
            5'd10:                                  n = 5'd13;
            5'd11:                                  n = 5'd16;
            5'd16, 5'd17, 5'd22:                    n = 5'd4;
            5'd19, 5'd20:                           n = 5'd5;
            default:                                n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// File: sv/keyword_lexer.sv
`timescale 1ns / 1ps
// Streaming tokenizer for a small keyword language.
// Input channel: source bytes (item.ch) with item.is_end on the final byte
// of a text; a transfer happens when push is high and full is low.
// Result channel: the oldest result sits on result while empty is low and is
// taken when pop is high. Each token gives its lexeme bytes (string bytes
// decoded) followed by a record carrying kind, start line and start column;
// result.last_of_run marks the final result caused by one input byte.
// Results pass through the queue and then an output register. The front lexer
// takes one byte per cycle while full is low and hands all its results
// (up to four) as one bundle to a queue of QUEUE_DEPTH bundles; the back
// end emits one result per cycle while pop is high, so bytes that make at
// most one result stream at one per cycle and bursts of up to four results
// drain from the queue. Bytes that make no result (spaces, comments) never
// enter the queue. When the receiver stalls, the result stays put and the
// queue fills; full rises once it holds QUEUE_DEPTH bundles.
// Reset clears the lexer to line 1, column 1, idle, and empties the queue.
// After the end record of a text the lexer returns to that same state.
module keyword_lexer #(
    parameter int QUEUE_DEPTH = kl_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  kl_pkg::lex_in_t  item,
    output logic             empty,
    input  logic             pop,
    output kl_pkg::lex_out_t result
);

    logic            q_write;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    kl_pkg::bundle_t q_wdata;
    kl_pkg::bundle_t q_rdata;

    kl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_full  (q_full),
        .item    (item),
        .q_write (q_write),
        .q_data  (q_wdata)
    );

    kl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_write),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd      (q_pop),
        .valid   (q_valid),
        .rd_data (q_rdata)
    );

    kl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign full = q_full;

endmodule

// File: sv/kl_front.sv
`timescale 1ns / 1ps

module kl_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             q_full,
    input  kl_pkg::lex_in_t  item,
    output logic             q_write,
    output kl_pkg::bundle_t  q_data
);

    localparam int LB = kl_pkg::LINE_BITS;
    localparam int CB = kl_pkg::COLUMN_BITS;

    kl_pkg::lex_mode_t mode_reg, mode_next;
    logic [LB-1:0] line_reg, line_next;
    logic [CB-1:0] col_reg, col_next;
    logic [CB-1:0] scol_reg, scol_next;
    logic [15:0]   slen_reg, slen_next;
    logic [4:0]    wlen_reg, wlen_next;
    logic [kl_pkg::NUM_KEYWORDS-1:0] cand_reg, cand_next;
    kl_pkg::lex_out_t [3:0] res;
    logic [2:0]    n_res;
    logic          accept;

    function automatic logic [CB-1:0] col_inc(input logic [CB-1:0] c);
        return (c == kl_pkg::COLUMN_MAX) ? c : c + {{(CB-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic kl_pkg::lex_out_t mk(input logic rec, input logic [5:0] kind,
                                            input logic [7:0] b, input logic [LB-1:0] ln,
                                            input logic [CB-1:0] cl);
        kl_pkg::lex_out_t r;
        r.is_record   = rec;
        r.kind        = kind;
        r.text_byte   = b;
        r.line        = ln;
        r.column      = cl;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Drop every keyword that no longer matches at position p.
    function automatic logic [kl_pkg::NUM_KEYWORDS-1:0] cand_step(
        input logic [kl_pkg::NUM_KEYWORDS-1:0] cand, input logic [4:0] p,
        input logic [7:0] c);
        logic [kl_pkg::NUM_KEYWORDS-1:0] r;
        logic [4:0] len;
        logic [4:0] idx;
        logic [8*kl_pkg::KEYWORD_MAX_LEN-1:0] w;
        r = cand;
        for (int k = 0; k < kl_pkg::NUM_KEYWORDS; k++)
        begin
            len = kl_pkg::kw_len(5'(k));
            w   = kl_pkg::kw_word(5'(k));
            idx = 5'(len - 5'd1 - p);
            if (!((p < len) && (w[idx[3:0]*8 +: 8] == c)))
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // First surviving keyword of the full length, else a plain identifier.
    function automatic logic [5:0] word_kind(
        input logic [kl_pkg::NUM_KEYWORDS-1:0] cand, input logic [4:0] wl);
        logic [5:0] kind;
        kind = kl_pkg::K_IDENT;
        for (int k = kl_pkg::NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (cand[k] && (kl_pkg::kw_len(5'(k)) == wl))
            begin
                kind = kl_pkg::K_KW0 + 6'(k);
            end
        end
        return kind;
    endfunction

    assign accept = push && !q_full;

    // Classify one byte and collect the results it causes.
    always_comb
    begin : classify
        logic       done;
        logic       fin;
        logic [7:0] c;
        logic [17:0] sum;
        logic [5:0]  single_kind;
        logic        is_single;
        done        = 1'b0;
        fin         = item.is_end;
        c           = item.ch;
        sum         = '0;
        single_kind = kl_pkg::K_ERROR;
        is_single   = 1'b0;
        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        scol_next = scol_reg;
        slen_next = slen_reg;
        wlen_next = wlen_reg;
        cand_next = cand_reg;
        res       = '0;
        n_res     = 3'd0;

        // Continue the token in progress.
        unique case (mode_reg)
            kl_pkg::MODE_NUM:
            begin
                if (is_digit(c))
                begin
                    res[n_res[1:0]] = mk(1'b0, kl_pkg::K_NUMBER, c, line_next, scol_next);
                    n_res = n_res + 3'd1;
                    col_next = col_inc(col_next);
                    done = 1'b1;
                end
                else
                begin
                    res[n_res[1:0]] = mk(1'b1, kl_pkg::K_NUMBER, 8'h00, line_next, scol_next);
                    n_res = n_res + 3'd1;
                    mode_next = kl_pkg::MODE_IDLE;
                end
            end
            kl_pkg::MODE_WORD:
            begin
                if (is_alpha(c) || is_digit(c) || (c == kl_pkg::CH_UNDERSCORE))
                begin
                    cand_next = cand_step(cand_next, wlen_next, c);
                    if (wlen_next != 5'd31)
                    begin
                        wlen_next = wlen_next + 5'd1;
                    end
                    res[n_res[1:0]] = mk(1'b0, kl_pkg::K_IDENT, c, line_next, scol_next);
                    n_res = n_res + 3'd1;
                    col_next = col_inc(col_next);
                    done = 1'b1;
                end
                else
                begin
                    res[n_res[1:0]] = mk(1'b1, word_kind(cand_next, wlen_next), 8'h00,
                                         line_next, scol_next);
                    n_res = n_res + 3'd1;
                    mode_next = kl_pkg::MODE_IDLE;
                end
            end
            kl_pkg::MODE_COMMENT:
            begin
                if (c == kl_pkg::CH_LF)
                begin
                    mode_next = kl_pkg::MODE_IDLE;
                end
                else
                begin
                    col_next = col_inc(col_next);
                    done = 1'b1;
                end
            end
            kl_pkg::MODE_STR:
            begin
                done = 1'b1;
                if (c == kl_pkg::CH_QUOTE)
                begin
                    sum = 18'(scol_next) + 18'(slen_next) + 18'd2;
                    col_next = (sum > 18'(kl_pkg::COLUMN_MAX)) ? kl_pkg::COLUMN_MAX
                                                               : CB'(sum);
                    res[n_res[1:0]] = mk(1'b1, kl_pkg::K_STRING, 8'h00, line_next, scol_next);
                    n_res = n_res + 3'd1;
                    mode_next = kl_pkg::MODE_IDLE;
                end
                else if ((c == kl_pkg::CH_BACKSLASH) && !fin)
                begin
                    mode_next = kl_pkg::MODE_ESC;
                end
                else
                begin
                    res[n_res[1:0]] = mk(1'b0, kl_pkg::K_STRING, c, line_next, scol_next);
                    n_res = n_res + 3'd1;
                    if (slen_next != 16'hFFFF)
                    begin
                        slen_next = slen_next + 16'd1;
                    end
                end
            end
            kl_pkg::MODE_ESC:
            begin
                done = 1'b1;
                mode_next = kl_pkg::MODE_STR;
                if ((c == kl_pkg::CH_N) || (c == kl_pkg::CH_T) || (c == kl_pkg::CH_QUOTE)
                    || (c == kl_pkg::CH_BACKSLASH))
                begin
                    res[n_res[1:0]] = mk(1'b0, kl_pkg::K_STRING,
                                         (c == kl_pkg::CH_N) ? kl_pkg::CH_LF :
                                         (c == kl_pkg::CH_T) ? kl_pkg::CH_TAB : c,
                                         line_next, scol_next);
                    n_res = n_res + 3'd1;
                    if (slen_next != 16'hFFFF)
                    begin
                        slen_next = slen_next + 16'd1;
                    end
                end
                else
                begin
                    // Unknown escape keeps both the backslash and the byte.
                    res[n_res[1:0]] = mk(1'b0, kl_pkg::K_STRING, kl_pkg::CH_BACKSLASH,
                                         line_next, scol_next);
                    n_res = n_res + 3'd1;
                    if (slen_next != 16'hFFFF)
                    begin
                        slen_next = slen_next + 16'd1;
                    end
                    res[n_res[1:0]] = mk(1'b0, kl_pkg::K_STRING, c, line_next, scol_next);
                    n_res = n_res + 3'd1;
                    if (slen_next != 16'hFFFF)
                    begin
                        slen_next = slen_next + 16'd1;
                    end
                end
            end
            kl_pkg::MODE_IDLE:
            begin
                mode_next = kl_pkg::MODE_IDLE;
            end
            default:
            begin
                mode_next = kl_pkg::MODE_IDLE;
            end
        endcase

        // Start a new token from an idle position.
        if (!done)
        begin
            if (c == kl_pkg::CH_LPAREN)
            begin
                is_single = 1'b1;
                single_kind = kl_pkg::K_LPAREN;
            end
            else if (c == kl_pkg::CH_RPAREN)
            begin
                is_single = 1'b1;
                single_kind = kl_pkg::K_RPAREN;
            end
            else if (c == kl_pkg::CH_COMMA)
            begin
                is_single = 1'b1;
                single_kind = kl_pkg::K_COMMA;
            end
            else if (c == kl_pkg::CH_COLON)
            begin
                is_single = 1'b1;
                single_kind = kl_pkg::K_COLON;
            end

            if (c == kl_pkg::CH_LF)
            begin
                res[n_res[1:0]] = mk(1'b0, kl_pkg::K_NEWLINE, kl_pkg::CH_LF,
                                     line_next, col_next);
                n_res = n_res + 3'd1;
                res[n_res[1:0]] = mk(1'b1, kl_pkg::K_NEWLINE, 8'h00, line_next, col_next);
                n_res = n_res + 3'd1;
                if (line_next != kl_pkg::LINE_MAX)
                begin
                    line_next = line_next + {{(LB-1){1'b0}}, 1'b1};
                end
                col_next = {{(CB-1){1'b0}}, 1'b1};
            end
            else if ((c == kl_pkg::CH_SPACE) || ((c >= kl_pkg::CH_TAB) && (c <= kl_pkg::CH_CR)))
            begin
                col_next = col_inc(col_next);
            end
            else if (c == kl_pkg::CH_HASH)
            begin
                mode_next = kl_pkg::MODE_COMMENT;
                col_next = col_inc(col_next);
            end
            else if (c == kl_pkg::CH_QUOTE)
            begin
                mode_next = kl_pkg::MODE_STR;
                scol_next = col_next;
                slen_next = 16'd0;
            end
            else if (is_digit(c))
            begin
                mode_next = kl_pkg::MODE_NUM;
                scol_next = col_next;
                res[n_res[1:0]] = mk(1'b0, kl_pkg::K_NUMBER, c, line_next, col_next);
                n_res = n_res + 3'd1;
                col_next = col_inc(col_next);
            end
            else if (is_alpha(c) || (c == kl_pkg::CH_UNDERSCORE))
            begin
                mode_next = kl_pkg::MODE_WORD;
                scol_next = col_next;
                cand_next = cand_step({kl_pkg::NUM_KEYWORDS{1'b1}}, 5'd0, c);
                wlen_next = 5'd1;
                res[n_res[1:0]] = mk(1'b0, kl_pkg::K_IDENT, c, line_next, col_next);
                n_res = n_res + 3'd1;
                col_next = col_inc(col_next);
            end
            else
            begin
                // Punctuation, or an error token for any other byte.
                res[n_res[1:0]] = mk(1'b0, is_single ? single_kind : kl_pkg::K_ERROR, c,
                                     line_next, col_next);
                n_res = n_res + 3'd1;
                res[n_res[1:0]] = mk(1'b1, is_single ? single_kind : kl_pkg::K_ERROR,
                                     8'h00, line_next, col_next);
                n_res = n_res + 3'd1;
                col_next = col_inc(col_next);
            end
        end

        // Close the open token at the end of the text and reset.
        if (fin)
        begin
            if (mode_next == kl_pkg::MODE_NUM)
            begin
                res[n_res[1:0]] = mk(1'b1, kl_pkg::K_NUMBER, 8'h00, line_next, scol_next);
                n_res = n_res + 3'd1;
            end
            else if (mode_next == kl_pkg::MODE_WORD)
            begin
                res[n_res[1:0]] = mk(1'b1, word_kind(cand_next, wlen_next), 8'h00,
                                     line_next, scol_next);
                n_res = n_res + 3'd1;
            end
            else if ((mode_next == kl_pkg::MODE_STR) || (mode_next == kl_pkg::MODE_ESC))
            begin
                sum = 18'(scol_next) + 18'(slen_next) + 18'd2;
                col_next = (sum > 18'(kl_pkg::COLUMN_MAX)) ? kl_pkg::COLUMN_MAX : CB'(sum);
                res[n_res[1:0]] = mk(1'b1, kl_pkg::K_STRING, 8'h00, line_next, scol_next);
                n_res = n_res + 3'd1;
            end
            res[n_res[1:0]] = mk(1'b1, kl_pkg::K_END, 8'h00, line_next, col_next);
            n_res = n_res + 3'd1;
            mode_next = kl_pkg::MODE_IDLE;
            line_next = {{(LB-1){1'b0}}, 1'b1};
            col_next  = {{(CB-1){1'b0}}, 1'b1};
            scol_next = {{(CB-1){1'b0}}, 1'b1};
            slen_next = 16'd0;
            wlen_next = 5'd0;
            cand_next = {kl_pkg::NUM_KEYWORDS{1'b1}};
        end

        if (n_res != 3'd0)
        begin
            res[2'(n_res - 3'd1)].last_of_run = 1'b1;
        end
    end

    assign q_write      = accept && (n_res != 3'd0);
    assign q_data.res   = res;
    assign q_data.count = n_res;

    // Lexer state advances once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= kl_pkg::MODE_IDLE;
            line_reg <= {{(LB-1){1'b0}}, 1'b1};
            col_reg  <= {{(CB-1){1'b0}}, 1'b1};
            scol_reg <= {{(CB-1){1'b0}}, 1'b1};
            slen_reg <= 16'd0;
            wlen_reg <= 5'd0;
            cand_reg <= {kl_pkg::NUM_KEYWORDS{1'b1}};
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            scol_reg <= scol_next;
            slen_reg <= slen_next;
            wlen_reg <= wlen_next;
            cand_reg <= cand_next;
        end
    end

    // A written bundle holds one to four results, the last one flagged.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_write |-> (q_data.count != 3'd0) && (q_data.count <= 3'd4))
        else $error("bundle count out of range");
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        q_write |-> q_data.res[2'(q_data.count - 3'd1)].last_of_run)
        else $error("last result of a bundle not flagged");
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.is_end) |=> (mode_reg == kl_pkg::MODE_IDLE) && (col_reg == 1))
        else $error("state not reset after end of text");

endmodule

// File: sv/kl_queue.sv
`timescale 1ns / 1ps

module kl_queue #(
    parameter int DEPTH = kl_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  kl_pkg::bundle_t wr_data,
    output logic            full,
    input  logic            rd,
    output logic            valid,
    output kl_pkg::bundle_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kl_pkg::bundle_t mem [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = mem[rp_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && valid;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wp_next  = do_wr ? ((wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = do_rd ? ((rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

endmodule

// File: sv/kl_back.sv
`timescale 1ns / 1ps

module kl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  kl_pkg::bundle_t   q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output kl_pkg::lex_out_t  result
);

    logic [1:0]       idx_reg, idx_next;
    logic             ov_reg, ov_next;
    kl_pkg::lex_out_t out_reg, out_next;
    logic             load;
    logic             last;

    assign load = q_valid && (!ov_reg || pop);
    assign last = (3'(idx_reg) + 3'd1) >= q_data.count;

    // Walk the head bundle one result per transfer.
    always_comb
    begin
        q_pop    = 1'b0;
        idx_next = idx_reg;
        out_next = out_reg;
        ov_next  = ov_reg && !pop;
        if (load)
        begin
            out_next = q_data.res[idx_reg];
            ov_next  = 1'b1;
            if (last)
            begin
                q_pop    = 1'b1;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty  = !ov_reg;
    assign result = out_reg;

    // The slot index always points inside the head bundle.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (3'(idx_reg) < q_data.count))
        else $error("result index beyond bundle");
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> load && out_next.last_of_run)
        else $error("bundle released before its last result");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !pop) |=> !empty && $stable(result))
        else $error("waiting result changed");

endmodule

// File: test/keyword_lexer_tb.sv
`timescale 1ns / 1ps

module keyword_lexer_tb;
    import kl_pkg::*;

    localparam int MODE_IDLE_C = 0;
    localparam int MODE_NUM_C = 1;
    localparam int MODE_WORD_C = 2;
    localparam int MODE_STR_C = 3;
    localparam int MODE_ESC_C = 4;
    localparam int MODE_COMMENT_C = 5;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    lex_in_t  item = '0;
    logic     empty;
    logic     pop = 1'b0;
    lex_out_t result;

    // Shadow tokenizer state.
    int                     lx_mode;
    logic [LINE_BITS-1:0]   lx_line;
    logic [COLUMN_BITS-1:0] lx_col;
    logic [COLUMN_BITS-1:0] lx_start;
    logic [15:0]            lx_slen;
    logic [4:0]             lx_wlen;
    logic [23:0]            lx_cand;

    lex_out_t token_queue[$];
    lex_out_t step_tokens[$];
    int       error_count = 0;
    int       send_idle_pct = 0;
    int       take_idle_pct = 0;

    keyword_lexer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    always #5 clk = ~clk;

    function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS+1:0] v);
        return (v > COLUMN_MAX) ? COLUMN_MAX : v[COLUMN_BITS-1:0];
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_wchar(input logic [7:0] c);
        return is_alp(c) || is_dig(c) || c == CH_UNDERSCORE;
    endfunction

    // Keyword spellings kept apart from the block's own tables.
    function automatic string kw_spell(input int k);
        string t[24] = '{"let", "be", "add", "subtract", "multiply", "divide",
            "equals", {"not_", "equals"}, {"less_", "than"}, {"greater_", "than"},
            {"less_or_", "equal"}, {"greater_or_", "equal"}, "and", "or", "not", "if",
            "then", "else", "end", "while", "begin", "say", "func", "return"};
        return t[k];
    endfunction

    task automatic lex_reset();
        lx_mode = MODE_IDLE_C;
        lx_line = 1;
        lx_col = 1;
        lx_start = 1;
        lx_slen = 0;
        lx_wlen = 0;
        lx_cand = '1;
    endtask

    task automatic add_token(input bit rec, input logic [5:0] k, input logic [7:0] b,
                             input logic [COLUMN_BITS-1:0] c);
        lex_out_t t;
        t.is_record = rec;
        t.kind = k;
        t.text_byte = b;
        t.line = lx_line;
        t.column = c;
        t.last_of_run = 1'b0;
        if (step_tokens.size() < 4)
            step_tokens.push_back(t);
    endtask

    task automatic add_str_byte(input logic [7:0] b);
        add_token(1'b0, K_STRING, b, lx_start);
        if (lx_slen != 16'hFFFF)
            lx_slen++;
    endtask

    task automatic word_add(input logic [7:0] c);
        string s;
        for (int k = 0; k < 24; k++)
        begin
            s = kw_spell(k);
            if (lx_cand[k] && !(lx_wlen < s.len() && s[lx_wlen] == c))
                lx_cand[k] = 1'b0;
        end
        if (lx_wlen != 5'd31)
            lx_wlen++;
        add_token(1'b0, K_IDENT, c, lx_start);
        lx_col = col_inc(lx_col + 1);
    endtask

    task automatic word_finish();
        logic [5:0] k;
        string s;
        k = K_IDENT;
        for (int i = 23; i >= 0; i--)
        begin
            s = kw_spell(i);
            if (lx_cand[i] && s.len() == lx_wlen)
                k = K_KW0 + 6'(i);
        end
        add_token(1'b1, k, 8'h00, lx_start);
    endtask

    task automatic str_finish();
        lx_col = col_inc(lx_start + lx_slen + 2);
        add_token(1'b1, K_STRING, 8'h00, lx_start);
    endtask

    task automatic punct(input logic [5:0] k, input logic [7:0] c);
        add_token(1'b0, k, c, lx_col);
        add_token(1'b1, k, 8'h00, lx_col);
        lx_col = col_inc(lx_col + 1);
    endtask

    // Work out the tokens caused by one source byte and queue them.
    task automatic predict_tokens(input lex_in_t it);
        logic [7:0] c;
        bit handled;
        c = it.ch;
        handled = 0;
        step_tokens.delete();
        case (lx_mode)
            MODE_NUM_C:
                if (is_dig(c))
                begin
                    add_token(1'b0, K_NUMBER, c, lx_start);
                    lx_col = col_inc(lx_col + 1);
                    handled = 1;
                end
                else
                begin
                    add_token(1'b1, K_NUMBER, 8'h00, lx_start);
                    lx_mode = MODE_IDLE_C;
                end
            MODE_WORD_C:
                if (is_wchar(c))
                begin
                    word_add(c);
                    handled = 1;
                end
                else
                begin
                    word_finish();
                    lx_mode = MODE_IDLE_C;
                end
            MODE_COMMENT_C:
                if (c == CH_LF)
                    lx_mode = MODE_IDLE_C;
                else
                begin
                    lx_col = col_inc(lx_col + 1);
                    handled = 1;
                end
            MODE_STR_C:
            begin
                handled = 1;
                if (c == CH_QUOTE)
                begin
                    str_finish();
                    lx_mode = MODE_IDLE_C;
                end
                else if (c == CH_BACKSLASH && !it.is_end)
                    lx_mode = MODE_ESC_C;
                else
                    add_str_byte(c);
            end
            MODE_ESC_C:
            begin
                handled = 1;
                if (c == CH_N)
                    add_str_byte(CH_LF);
                else if (c == CH_T)
                    add_str_byte(CH_TAB);
                else if (c == CH_QUOTE || c == CH_BACKSLASH)
                    add_str_byte(c);
                else
                begin
                    add_str_byte(CH_BACKSLASH);
                    add_str_byte(c);
                end
                lx_mode = MODE_STR_C;
            end
            default:
                lx_mode = MODE_IDLE_C;
        endcase
        if (!handled)
        begin
            if (c == CH_LF)
            begin
                add_token(1'b0, K_NEWLINE, CH_LF, lx_col);
                add_token(1'b1, K_NEWLINE, 8'h00, lx_col);
                if (lx_line != LINE_MAX)
                    lx_line++;
                lx_col = 1;
            end
            else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                lx_col = col_inc(lx_col + 1);
            else if (c == CH_HASH)
            begin
                lx_mode = MODE_COMMENT_C;
                lx_col = col_inc(lx_col + 1);
            end
            else if (c == CH_QUOTE)
            begin
                lx_mode = MODE_STR_C;
                lx_start = lx_col;
                lx_slen = 0;
            end
            else if (is_dig(c))
            begin
                lx_mode = MODE_NUM_C;
                lx_start = lx_col;
                add_token(1'b0, K_NUMBER, c, lx_start);
                lx_col = col_inc(lx_col + 1);
            end
            else if (c == CH_LPAREN)
                punct(K_LPAREN, c);
            else if (c == CH_RPAREN)
                punct(K_RPAREN, c);
            else if (c == CH_COMMA)
                punct(K_COMMA, c);
            else if (c == CH_COLON)
                punct(K_COLON, c);
            else if (is_alp(c) || c == CH_UNDERSCORE)
            begin
                lx_mode = MODE_WORD_C;
                lx_start = lx_col;
                lx_wlen = 0;
                lx_cand = '1;
                word_add(c);
            end
            else
                punct(K_ERROR, c);
        end
        if (it.is_end)
        begin
            if (lx_mode == MODE_NUM_C)
                add_token(1'b1, K_NUMBER, 8'h00, lx_start);
            else if (lx_mode == MODE_WORD_C)
                word_finish();
            else if (lx_mode == MODE_STR_C || lx_mode == MODE_ESC_C)
                str_finish();
            add_token(1'b1, K_END, 8'h00, lx_col);
            lex_reset();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
        foreach (step_tokens[i])
            token_queue.push_back(step_tokens[i]);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Send one byte; the transfer completes at an edge with push high and full low.
    // push stays high afterwards until the next idle cycle or the final drain.
    task automatic send_byte(input logic [7:0] c, input bit fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{ch: c, is_end: fin};
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_tokens('{ch: c, is_end: fin});
    endtask

    task automatic send_text(input string s, input bit fin);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin && i == s.len() - 1);
    endtask

    // Receiver: random stalls, checks each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        lex_out_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (token_queue.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", result));
                else
                begin
                    e = token_queue.pop_front();
                    if (result.is_record !== e.is_record)
                        report_mismatch($sformatf("is_record %b exp %b", result.is_record,
                                                  e.is_record));
                    if (result.kind !== e.kind)
                        report_mismatch($sformatf("kind %0d exp %0d", result.kind, e.kind));
                    if (result.text_byte !== e.text_byte)
                        report_mismatch($sformatf("text_byte %h exp %h", result.text_byte,
                                                  e.text_byte));
                    if (result.line !== e.line)
                        report_mismatch($sformatf("line %0d exp %0d", result.line, e.line));
                    if (result.column !== e.column)
                        report_mismatch($sformatf("column %0d exp %0d", result.column,
                                                  e.column));
                    if (result.last_of_run !== e.last_of_run)
                        report_mismatch($sformatf("last_of_run %b exp %b", result.last_of_run,
                                                  e.last_of_run));
                end
            end
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    task automatic test_tokens();
        send_text("let x be 42, (y): @\n", 0);
        send_text("# c\nsay \"a\\nb\\tc\\\"d\\\\e\\qf\"\n", 0);
        send_text("returnx _a9 RETURN", 1);
    endtask

    // A spread of keywords, the longest one included.
    task automatic test_keywords();
        for (int k = 0; k < 24; k++)
        begin
            if ((k % 3 == 0) || (k == 11))
                send_text({kw_spell(k), " "}, 0);
        end
        send_byte(CH_LF, 1);
    endtask

    task automatic test_edges();
        send_byte(8'hFF, 0);
        send_byte(8'h00, 0);
        send_byte(8'h80, 0);
        send_text("\"open\\", 1);
        send_text("12", 1);
        send_text("\"x", 1);
        send_text("abc", 1);
        send_byte("#", 1);
        send_byte(CH_LF, 1);
        send_text("aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa ", 0);
        send_text("\"ab\ncd\" z", 1);
    endtask

    // Random texts built mostly from well-formed tokens, with noise mixed in.
    task automatic test_random(input int n_items);
        string frag;
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(9))
                0: frag = kw_spell($urandom_range(23));
                1: frag = $sformatf("%0d", $urandom);
                2: frag = "\"s\\n\\t\\q\"";
                3: frag = "(a_1, b):";
                4: frag = "# c\n";
                5: frag = "\n";
                6: frag = {kw_spell($urandom_range(23)), "_z"};
                7: frag = " \t";
                default:
                begin
                    frag = " ";
                    frag[0] = $urandom_range(255);
                end
            endcase
            for (int i = 0; i < frag.len(); i++)
                send_byte(frag[i], $urandom_range(39) == 0);
            sent += frag.len();
            if ($urandom_range(3) == 0)
                send_byte(" ", 0);
        end
        send_byte(CH_LF, 1);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        lex_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 6;
        take_idle_pct = 63;
        test_tokens();
        test_keywords();
        test_edges();
        test_random(6);
        send_idle_pct = 63;
        take_idle_pct = 6;
        test_random(6);
        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random(6);
        drain();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
